### rtl/core/fwdde_pkg.sv
// Package for the fixed-width decimal digit emitter.
// Holds field widths, character codes and parameter defaults; no dependencies.
package fwdde_pkg;

	localparam int DEF_NUMBER_BITS = 32;
	localparam int DEF_MAX_DIGITS  = 10;

	localparam int COUNT_W     = 4;
	localparam int DIGIT_W     = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] ASCII_NINE = 6'd57;

endpackage

### rtl/core/fwdde_front.sv
// Front stage: takes input transfers, clamps the digit count and drops empty runs.
// Depends on fwdde_pkg; feeds fwdde_queue.
module fwdde_front #(
	parameter int NUMBER_BITS = fwdde_pkg::DEF_NUMBER_BITS,
	parameter int MAX_DIGITS  = fwdde_pkg::DEF_MAX_DIGITS,
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NUMBER_BITS-1:0]        number,
	input  logic [fwdde_pkg::COUNT_W-1:0] digit_count,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [NUMBER_BITS-1:0]        push_number,
	output logic [CNT_W-1:0]              push_count
);

	logic                   valid_q;
	logic [NUMBER_BITS-1:0] number_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       clamped;
	logic                   drain;

	always_comb begin
		if (int'(digit_count) > MAX_DIGITS) begin
			clamped = CNT_W'(MAX_DIGITS);
		end else begin
			clamped = CNT_W'(digit_count);
		end
	end

	assign push_valid  = valid_q && (count_q != '0);
	assign drain       = valid_q && ((count_q == '0) || push_ready);
	assign in_ready    = !valid_q || drain;
	assign push_number = number_q;
	assign push_count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (drain) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			number_q <= number;
			count_q  <= clamped;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (int'(count_q) <= MAX_DIGITS))
		else $error("Front holds a count above the digit limit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !drain) |=> (valid_q && $stable(count_q) && $stable(number_q)))
		else $error("Front item changed before its transfer into the queue.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_q)
		else $error("Accepted item was not captured by the front stage.");

endmodule

### rtl/core/fwdde_queue.sv
// Short queue between the front stage and the conversion unit.
// Depends on fwdde_pkg for its depth.
module fwdde_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = fwdde_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		if (ptr == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return ptr + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("Queue fill count exceeds its depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("Queue fill count did not follow a lone push.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("Empty queue has unequal pointers.");

endmodule

### rtl/core/fwdde_back.sv
// Conversion unit: shift-and-add-3 binary to BCD, one bit per cycle,
// then sends the requested low digits as ASCII, most significant first. Depends on fwdde_pkg.
module fwdde_back #(
	parameter int NUMBER_BITS = fwdde_pkg::DEF_NUMBER_BITS,
	parameter int MAX_DIGITS  = fwdde_pkg::DEF_MAX_DIGITS,
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  logic [NUMBER_BITS-1:0]        pop_number,
	input  logic [CNT_W-1:0]              pop_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fwdde_pkg::DIGIT_W-1:0] ascii_digit,
	output logic                          last_digit
);

	localparam int FULL_DIGITS = (NUMBER_BITS * 30103) / 100000 + 1;
	localparam int NDIG        = (FULL_DIGITS > MAX_DIGITS) ? FULL_DIGITS : MAX_DIGITS;
	localparam int BCD_W       = 4 * NDIG;
	localparam int IDX_W       = $clog2(NDIG);
	localparam int BIT_W       = $clog2(NUMBER_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [NUMBER_BITS-1:0]          number_q;
	logic [BCD_W-1:0]                bcd_q;
	logic [BIT_W-1:0]                bit_cnt_q;
	logic [IDX_W-1:0]                idx_q;
	logic [CNT_W-1:0]                count_q;
	logic                            out_valid_q;
	logic [fwdde_pkg::DIGIT_W-1:0]   ascii_q;
	logic                            last_q;
	logic [BCD_W-1:0]                adjusted;
	logic [3:0]                      cur_digit;
	logic                            load;

	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adjusted[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adjusted[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	assign cur_digit   = bcd_q[4*idx_q +: 4];
	assign pop_ready   = (state_q == ST_IDLE);
	assign load        = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign ascii_digit = ascii_q;
	assign last_digit  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			ascii_q     <= fwdde_pkg::ASCII_ZERO;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + BIT_W'(1);
					if (bit_cnt_q == BIT_W'(NUMBER_BITS - 1)) begin
						idx_q   <= IDX_W'(count_q - CNT_W'(1));
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						ascii_q     <= fwdde_pkg::ASCII_ZERO + fwdde_pkg::DIGIT_W'(cur_digit);
						last_q      <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			number_q <= pop_number;
			count_q  <= pop_count;
			bcd_q    <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q    <= {adjusted[BCD_W-2:0], number_q[NUMBER_BITS-1]};
			number_q <= {number_q[NUMBER_BITS-2:0], 1'b0};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ascii_q >= fwdde_pkg::ASCII_ZERO && ascii_q <= fwdde_pkg::ASCII_NINE))
		else $error("Emitted character is not a decimal digit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (int'(idx_q) < int'(count_q)))
		else $error("Digit position outside the requested run.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && load && idx_q == '0) |=> (state_q == ST_IDLE && last_q))
		else $error("Final digit was not marked or the run did not end.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (count_q != '0))
		else $error("Conversion started for an empty run.");

endmodule

### rtl/core/fixed_width_decimal_digit_emitter_top.sv
// Top level of the fixed-width decimal digit emitter.
// Instantiates fwdde_front, fwdde_queue and fwdde_back; depends on fwdde_pkg.
//
// Usage:
// The input channel (in_valid/in_ready) carries a binary number and a digit
// count. Each transfer produces that many output transfers on out_valid/
// out_ready, one ASCII digit '0' to '9' each, most significant first, with
// last_digit set on the final one. Only the low decimal digits are sent and
// leading positions read '0'. A count of zero sends nothing; a count above
// MAX_DIGITS is treated as MAX_DIGITS.
// Timing: the conversion unit shifts one bit of the number per cycle, then
// sends the digits; it takes the next item only once the final digit of the
// current one has been loaded into the output register.
// A front register and a two-entry queue accept further items while the
// conversion unit is busy. When the receiver stalls, the current digit holds
// in the output register and the conversion unit waits; the input side keeps
// taking items until the queue and the front register are full.
// Reset clears the queue, the front register and the output valid; no item
// survives it, and no clearing pass is needed afterwards.
module fixed_width_decimal_digit_emitter_top #(
	parameter int NUMBER_BITS = fwdde_pkg::DEF_NUMBER_BITS,
	parameter int MAX_DIGITS  = fwdde_pkg::DEF_MAX_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NUMBER_BITS-1:0]        number,
	input  logic [fwdde_pkg::COUNT_W-1:0] digit_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fwdde_pkg::DIGIT_W-1:0] ascii_digit,
	output logic                          last_digit
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int QW    = NUMBER_BITS + CNT_W;

	logic                   push_valid;
	logic                   push_ready;
	logic [NUMBER_BITS-1:0] push_number;
	logic [CNT_W-1:0]       push_count;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [QW-1:0]          pop_data;

	fwdde_front #(
		.NUMBER_BITS(NUMBER_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.number     (number),
		.digit_count(digit_count),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_number(push_number),
		.push_count (push_count)
	);

	fwdde_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_count, push_number}),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	fwdde_back #(
		.NUMBER_BITS(NUMBER_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_number (pop_data[NUMBER_BITS-1:0]),
		.pop_count  (pop_data[QW-1:NUMBER_BITS]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_digit(ascii_digit),
		.last_digit (last_digit)
	);

endmodule
